@@ sv/bds_pkg.sv @@
// Shared types and constants of the 2x2 RGBA box downscaler.
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

   // Pixel layout and arithmetic widths.
   localparam int CHANNELS  = 4;
   localparam int CH_W      = 8;
   localparam int PIX_W     = CHANNELS * CH_W;
   localparam int PAIR_W    = CH_W + 1;           // sum of two channel values
   localparam int BLOCK_W   = CH_W + 2;           // sum of four channel values
   localparam int STORE_W   = CHANNELS * PAIR_W;

   // Configuration register port.
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 2;

   localparam int FRAME_WIDTH_RST  = 640;
   localparam int FRAME_HEIGHT_RST = 480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // Channel 0 (red) sits in the lowest bits.
   typedef logic [CHANNELS-1:0][CH_W-1:0]   rgba_type;
   typedef logic [CHANNELS-1:0][PAIR_W-1:0] pair_type;

endpackage

`default_nettype wire

@@ sv/box_downscale_2x2_rgba.sv @@
// Top level of the 2x2 box-filter downscaler for RGBA pixel streams.
`timescale 1ns / 1ps
`default_nettype none

// The block takes source pixels in raster order, one per beat, and returns
// one half-size pixel per 2x2 block whose channels are the truncated mean
// of the four source channels. It accepts one pixel every clock cycle: the
// only per-pixel work is a 9-bit add per channel and one access to the line
// store, a single-port-write, single-port-read RAM of MAX_WIDTH/2 entries
// with registered read data. The pixel that completes a block (the
// odd-column pixel of an odd row) starts the line store read and is held
// with its pair sum in the read stage; the final add then goes into the output
// register. The output register lets the next pixel in while a result still
// waits, so the input stalls only when both the result register and the
// read stage are full and the sink holds off. An odd last column or row is
// consumed and gives nothing. Writing either size register restarts the
// frame; do so only while no results are outstanding. Sizes are clamped to
// the range from 2 to MAX_WIDTH or MAX_HEIGHT. No clearing pass is needed
// after reset: every line store entry is written on an even row before the
// odd row below reads it.
module box_downscale_2x2_rgba #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_tvalid,
   output logic                         req_tready,
   // red [7:0], green [15:8], blue [23:16], alpha [31:24]
   input  logic [bds_pkg::PIX_W-1:0]    req_tdata,

   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // out_red [7:0], out_green [15:8], out_blue [23:16], out_alpha [31:24]
   output logic [bds_pkg::PIX_W-1:0]    rsp_tdata,
   output logic                         rsp_tlast,     // frame_last

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bds_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bds_pkg::CFG_W-1:0]    csr_data
);

   import bds_pkg::*;

   // Column and row counters index positions below the maximum sizes; the
   // effective sizes need one more bit to hold the maximum itself.
   localparam int CW      = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW      = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WD_W    = $clog2(MAX_WIDTH + 1);
   localparam int HD_W    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH   = MAX_WIDTH / 2;
   localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   function automatic logic [WD_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
      int vi;
      vi = int'(v);
      if (vi < 2) begin
         vi = 2;
      end else if (vi > MAX_WIDTH) begin
         vi = MAX_WIDTH;
      end
      return WD_W'(vi);
   endfunction

   function automatic logic [HD_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
      int vi;
      vi = int'(v);
      if (vi < 2) begin
         vi = 2;
      end else if (vi > MAX_HEIGHT) begin
         vi = MAX_HEIGHT;
      end
      return HD_W'(vi);
   endfunction

   // Effective (clamped) frame size, kept from the last register write.
   logic [WD_W-1:0] width_ff,  width_in;
   logic [HD_W-1:0] height_ff, height_in;

   // Position of the next source pixel and the running horizontal pair sum.
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   pair_type        pair_ff, pair_in;

   // Read stage: pair sum of the odd row waiting for the line store data.
   logic            s1_valid_ff, s1_valid_in;
   pair_type        s1_pair_ff, s1_pair_in;
   logic            s1_last_ff, s1_last_in;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   rgba_type        rsp_data_ff, rsp_data_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            accept;
   logic            cfg_write;
   logic            out_free;
   logic            s1_advance;
   logic            col_end, row_end;
   logic            col_used, row_used;
   logic            in_frame;
   logic            block_last;
   logic [WD_W-1:0] last_used_col;
   logic [HD_W-1:0] last_used_row;
   logic            wr_en, rd_en;
   logic [SLOT_W-1:0] slot;
   rgba_type        px;
   pair_type        pair_sum;
   pair_type        store_rd;
   logic [BLOCK_W-1:0] block_sum [CHANNELS];

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   // The input stalls only while the read stage holds a result that cannot
   // move into a full, unconsumed output register.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   assign px = rgba_type'(req_tdata);

   // Frame geometry of the current pixel.
   assign col_end       = (WD_W'(col_ff) == width_ff - WD_W'(1));
   assign row_end       = (HD_W'(row_ff) == height_ff - HD_W'(1));
   assign col_used      = !(col_end && width_ff[0]);
   assign row_used      = !(row_end && height_ff[0]);
   assign in_frame      = col_used && row_used;
   assign last_used_col = (width_ff  & ~WD_W'(1)) - WD_W'(1);
   assign last_used_row = (height_ff & ~HD_W'(1)) - HD_W'(1);
   assign block_last    = (WD_W'(col_ff) == last_used_col) &&
                          (HD_W'(row_ff) == last_used_row);

   assign slot = SLOT_W'(col_ff >> 1);

   // Even column starts a pair, odd column completes it.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (col_ff[0]) begin
            pair_sum[c] = pair_ff[c] + {1'b0, px[c]};
         end else begin
            pair_sum[c] = {1'b0, px[c]};
         end
      end
   end

   // Even rows park their pair sums in the line store; odd rows read them
   // back. A write and the later read of the same entry are at least one
   // beat apart, so the RAM needs no forwarding path.
   assign wr_en = accept && in_frame && col_ff[0] && !row_ff[0];
   assign rd_en = accept && in_frame && col_ff[0] &&  row_ff[0];

   bds_line_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (SLOT_W),
      .DATA_W (STORE_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (STORE_W'(pair_sum)),
      .rd_en   (rd_en),
      .rd_addr (slot),
      .rd_data (store_rd)
   );

   // Next frame position, size registers and pair sum.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pair_in   = pair_ff;
      if (cfg_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_in = clamp_width(csr_data);
            end
            CSR_FRAME_HEIGHT: begin
               height_in = clamp_height(csr_data);
            end
            default: begin
            end
         endcase
         if ((csr_index == CSR_FRAME_WIDTH) || (csr_index == CSR_FRAME_HEIGHT)) begin
            col_in  = '0;
            row_in  = '0;
            pair_in = '0;
         end
      end else if (accept) begin
         if (in_frame) begin
            pair_in = pair_sum;
         end
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // Read stage and output register.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_pair_in   = s1_pair_ff;
      s1_last_in   = s1_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      for (int c = 0; c < CHANNELS; c++) begin
         block_sum[c] = BLOCK_W'(store_rd[c]) + BLOCK_W'(s1_pair_ff[c]);
      end

      if (rd_en) begin
         s1_valid_in = 1'b1;
         s1_pair_in  = pair_sum;
         s1_last_in  = block_last;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = s1_last_ff;
         for (int c = 0; c < CHANNELS; c++) begin
            rsp_data_in[c] = block_sum[c][BLOCK_W-1:2];
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= clamp_width(CFG_W'(FRAME_WIDTH_RST));
         height_ff    <= clamp_height(CFG_W'(FRAME_HEIGHT_RST));
         col_ff       <= '0;
         row_ff       <= '0;
         pair_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pair_ff      <= pair_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pair_ff  <= s1_pair_in;
      s1_last_ff  <= s1_last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = PIX_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

@@ sv/bds_line_store.sv @@
// Line store RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bds_line_store #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 36
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read, so a stalled consumer keeps it.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/bds_checker.sv @@
// Port-level checks of the downscaler and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bds_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [bds_pkg::PIX_W-1:0] rsp_tdata,
   input logic                      rsp_tlast
);

   // A result held off by the sink keeps its beat unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A fresh result must follow an accepted input beat.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result appeared without a completing input beat");

   // The input only stalls under output backpressure.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled while output was free");

endmodule

bind box_downscale_2x2_rgba bds_checker u_bds_checker (.*);

`default_nettype wire

@@ tb/box_downscale_2x2_rgba_checker.sv @@
// Scoreboard for the 2x2 RGBA box downscaler: tracks position, predicts block means, compares.
`timescale 1ns / 1ps

module box_downscale_2x2_rgba_checker #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [bds_pkg::PIX_W-1:0]     req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [bds_pkg::PIX_W-1:0]     rsp_tdata,
   input  logic                          rsp_tlast,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [bds_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bds_pkg::CFG_W-1:0]     csr_data,
   output int                            mismatches,
   output int                            blocks_owed
);

   import bds_pkg::*;

   localparam int LINE_PAIRS = MAX_WIDTH / 2;
   localparam int REPORT_CAP = 40;

   typedef struct packed {
      rgba_type mean;
      logic     frame_end;
   } block_type;

   string            channel_name [CHANNELS] = '{"out_red", "out_green", "out_blue", "out_alpha"};

   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   int unsigned      col;
   int unsigned      row;
   pair_type         pair_acc;
   pair_type         line_pairs [LINE_PAIRS];
   block_type        owed_blocks [$];
   int               fail_count = 0;
   int               reports    = 0;

   initial begin
      mismatches  = 0;
      blocks_owed = 0;
   end

   function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic void restart_frame();
      col      = 0;
      row      = 0;
      pair_acc = '0;
   endfunction

   function automatic void report(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      fail_count++;
      if (reports < REPORT_CAP) begin
         reports++;
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
   endfunction

   // Steps the frame position by one source pixel and queues a block mean when the
   // pixel is the bottom-right corner of a 2x2 block.
   function automatic void take_pixel(input rgba_type pix);
      int unsigned        w;
      int unsigned        h;
      int unsigned        used_w;
      int unsigned        used_h;
      int unsigned        slot;
      logic [BLOCK_W-1:0] sum;
      block_type          blk;
      w      = clamp_size(width_reg, MAX_WIDTH);
      h      = clamp_size(height_reg, MAX_HEIGHT);
      used_w = (w / 2) * 2;
      used_h = (h / 2) * 2;
      if (col < used_w && row < used_h) begin
         slot = (col / 2) % LINE_PAIRS;
         if (col % 2 == 0) begin
            for (int c = 0; c < CHANNELS; c++) pair_acc[c] = PAIR_W'(pix[c]);
         end else begin
            for (int c = 0; c < CHANNELS; c++) pair_acc[c] = pair_acc[c] + PAIR_W'(pix[c]);
            if (row % 2 == 0) begin
               line_pairs[slot] = pair_acc;
            end else begin
               for (int c = 0; c < CHANNELS; c++) begin
                  sum         = BLOCK_W'(line_pairs[slot][c]) + BLOCK_W'(pair_acc[c]);
                  blk.mean[c] = sum[BLOCK_W-1:2];
               end
               blk.frame_end = (row == used_h - 1) && (col == used_w - 1);
               owed_blocks.push_back(blk);
            end
         end
      end
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
   endfunction

   function automatic void check_block(input rgba_type got, input logic got_end);
      block_type want;
      if (owed_blocks.size() == 0) begin
         fail_count++;
         if (reports < REPORT_CAP) begin
            reports++;
            $display("%0t: no result expected, got data 0x%0h last %0b", $time, got, got_end);
         end
         return;
      end
      want = owed_blocks.pop_front();
      for (int c = 0; c < CHANNELS; c++)
         if (got[c] !== want.mean[c]) report(channel_name[c], 32'(want.mean[c]), 32'(got[c]));
      if (got_end !== want.frame_end) report("frame_last", 32'(want.frame_end), 32'(got_end));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = CFG_W'(FRAME_WIDTH_RST);
         height_reg = CFG_W'(FRAME_HEIGHT_RST);
         restart_frame();
         owed_blocks.delete();
      end else begin
         // Results first, so a pixel accepted on this edge cannot satisfy its own check.
         if (rsp_tvalid && rsp_tready) check_block(rsp_tdata, rsp_tlast);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  width_reg = csr_data;
                  restart_frame();
               end
               CSR_FRAME_HEIGHT: begin
                  height_reg = csr_data;
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_pixel(req_tdata);
      end
      mismatches  <= fail_count;
      blocks_owed <= owed_blocks.size();
   end

endmodule

@@ tb/box_downscale_2x2_rgba_test.sv @@
// Top of the 2x2 RGBA box downscaler testbench: clock, reset, stimulus, sink and verdict.
`timescale 1ns / 1ps

// The top drives pixel beats and size register writes into the downscaler and
// accepts the half-size pixels it returns. Checking lives in the checker
// instance beside the block and the bound port checks; this module only reads its
// mismatch count and the number of blocks still owed, and prints the verdict.
module box_downscale_2x2_rgba_test;
   import bds_pkg::*;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int RANDOM_PIXELS = 620;
   localparam int IDLE_PCT      = 11;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 200;

   // Register indexes the block does not decode; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam logic [CFG_W-1:0]     CFG_ALL_ONES = '1;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [PIX_W-1:0]     req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [PIX_W-1:0]     rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]     csr_data   = '0;

   int                   mismatches;
   int                   blocks_owed;

   // When steady is high neither side idles. When squeeze rises the sink stops
   // taking results for a long stretch while the source keeps offering pixels.
   logic                 steady  = 1'b0;
   logic                 squeeze = 1'b0;

   // Size register values last written by the random part, kept so that a
   // phase writing only one register knows the other one.
   logic [CFG_W-1:0] u_checker_width_shadow  = '0;
   logic [CFG_W-1:0] u_checker_height_shadow = '0;

   always #10 clock = ~clock;

   box_downscale_2x2_rgba #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   box_downscale_2x2_rgba_checker #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .blocks_owed (blocks_owed)
   );

   // The effective frame size after the block's saturation of a register value.
   function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   // Offers one pixel beat, with a random idle gap in front of it unless the
   // steady stretch is on, and returns on the edge that accepts it. Valid stays
   // high afterwards so back-to-back beats need no second assignment.
   task automatic send_pixel(input rgba_type pix);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random(input int unsigned count);
      repeat (count) send_pixel($urandom());
   endtask

   // Stops the source, waits until every owed block has come back, then gives the
   // block's pipeline time to finish pixels that make no result.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (blocks_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write beat. With more set, valid stays high for a write that
   // follows right away.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value,
                            input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (!more) csr_valid <= 1'b0;
   endtask

   task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      write_csr(CSR_FRAME_WIDTH, w, 1'b1);
      write_csr(CSR_FRAME_HEIGHT, h, 1'b0);
   endtask

   // The sink takes results at random, except for one long hold-off triggered
   // by squeeze, during which the block's few result slots fill and the input
   // has to stall.
   initial begin : result_sink
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin : stimulus
      logic [CFG_W-1:0] w_set;
      logic [CFG_W-1:0] h_set;
      int unsigned      frame_px;
      int unsigned      lead;
      int unsigned      total;
      int unsigned      random_sent;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // With the reset sizes (640 x 480) a short run stays inside the first row
      // and yields nothing. The frame is then left unfinished, so the next
      // register write also has to restart it mid-frame.
      send_random(24);
      drain();

      // Zero and one saturate to the smallest frame, 2 x 2, so every fourth pixel
      // closes a frame and the counters wrap on each one.
      set_frame('0, 13'd1);
      repeat (4) send_pixel('1);
      repeat (4) send_pixel('0);
      // Truncation: red sums to 3 (mean 0), green to 1019 (mean 254), alpha to
      // 518 (mean 129).
      send_pixel({8'd128, 8'd2, 8'd255, 8'd1});
      send_pixel({8'd129, 8'd0, 8'd255, 8'd1});
      send_pixel({8'd130, 8'd0, 8'd255, 8'd1});
      send_pixel({8'd131, 8'd0, 8'd254, 8'd0});
      drain();

      // Odd width and height: the last column and the last row are swallowed.
      set_frame(13'd3, 13'd3);
      send_random(9);
      drain();

      // All-ones width saturates to MAX_WIDTH, so a short run stays in the first
      // row and must give nothing.
      set_frame(CFG_ALL_ONES, 13'd2);
      send_random(30);
      drain();

      // A 4 x 2 frame where every other pixel of the second row completes a
      // block. Once the second row is reached the sink holds off for a long
      // stretch while the source keeps pushing.
      set_frame(13'd4, 13'd2);
      send_random(12);
      squeeze <= 1'b1;
      send_random(40);
      drain();

      // All-ones height saturates to MAX_HEIGHT, with no idling on either side;
      // no result of this run may carry the frame end mark.
      steady <= 1'b1;
      set_frame(13'd1, CFG_ALL_ONES);
      send_random(100);
      drain();
      steady <= 1'b0;

      // Random small frames, mostly whole frames, sometimes cut short. Now and
      // then only one size register is written, and an undecoded index is written
      // in mid-frame, which must not restart the frame.
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         case ($urandom_range(9))
            0:       w_set = CFG_W'($urandom_range(1));
            1:       w_set = CFG_W'($urandom_range(13, 40));
            default: w_set = CFG_W'($urandom_range(2, 12));
         endcase
         case ($urandom_range(9))
            0:       h_set = CFG_W'($urandom_range(1));
            1:       h_set = CFG_W'($urandom_range(11, 20));
            default: h_set = CFG_W'($urandom_range(2, 9));
         endcase
         if (random_sent != 0 && $urandom_range(7) == 0) begin
            if ($urandom_range(1) == 0) begin
               write_csr(CSR_FRAME_WIDTH, w_set, 1'b0);
               h_set = u_checker_height_shadow;
            end else begin
               write_csr(CSR_FRAME_HEIGHT, h_set, 1'b0);
               w_set = u_checker_width_shadow;
            end
         end else begin
            set_frame(w_set, h_set);
         end
         u_checker_width_shadow  = w_set;
         u_checker_height_shadow = h_set;

         frame_px = clamp_size(w_set, MAX_WIDTH) * clamp_size(h_set, MAX_HEIGHT);
         total    = frame_px * (frame_px > 100 ? 1 : $urandom_range(1, 3));
         if ($urandom_range(3) == 0) total = total + $urandom_range(1, frame_px - 1);
         if (total > RANDOM_PIXELS - random_sent) total = RANDOM_PIXELS - random_sent;

         if ($urandom_range(3) == 0) begin
            lead = $urandom_range(1, total);
            send_random(lead);
            drain();
            write_csr(($urandom_range(1) == 0) ? CSR_SPARE_LO : CSR_SPARE_HI,
                      CFG_W'($urandom()), 1'b0);
            send_random(total - lead);
         end else begin
            send_random(total);
         end
         drain();
         random_sent = random_sent + total;
      end

      if (mismatches == 0 && blocks_owed == 0) begin
         $display("box_downscale_2x2_rgba_test passed");
      end else begin
         $display("box_downscale_2x2_rgba_test failed");
      end
      $finish;
   end

   // A stuck run is ended as failed; the limit allows far more than the slowest correct run.
   initial begin : watchdog
      #20_000_000;
      $display("box_downscale_2x2_rgba_test failed");
      $finish;
   end

endmodule
